// File: rtl/x86p_pkg.sv
// ----------------------------------------------------------------------------
// x86p_pkg: shared types and helpers for the 8086 instruction predecoder
// Word formats of both channels, decoder state, field codes and the small
// opcode classification functions used by the step logic.
// ----------------------------------------------------------------------------
package x86p_pkg;

	// Decoder phase within one instruction.
	typedef enum logic [2:0] {
		PH_OPCODE  = 3'd0,
		PH_MODRM   = 3'd1,
		PH_DISP_LO = 3'd2,
		PH_DISP_HI = 3'd3,
		PH_IMM_LO  = 3'd4,
		PH_IMM_HI  = 3'd5
	} phase_t;

	// Opcode classes.
	typedef enum logic [2:0] {
		K_RMREG   = 3'd0,
		K_GROUP   = 3'd1,
		K_MOVIR   = 3'd2,
		K_ACC     = 3'd3,
		K_MOVIRM  = 3'd4,
		K_UNKNOWN = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		OP_MOV = 2'd0,
		OP_ADD = 2'd1,
		OP_SUB = 2'd2,
		OP_CMP = 2'd3
	} operation_t;

	typedef enum logic [1:0] {
		FM_RM_REG  = 2'd0,
		FM_IMM_RM  = 2'd1,
		FM_IMM_REG = 2'd2,
		FM_IMM_ACC = 2'd3
	} form_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNKNOWN   = 3'd1,
		ST_NOT_IMPL  = 3'd2,
		ST_BAD_SUBOP = 3'd3,
		ST_TRUNCATED = 3'd4
	} status_t;

	// Arithmetic selector values in opcode bits 5:3 or ModRM reg.
	localparam logic [2:0] SEL_ADD = 3'b000;
	localparam logic [2:0] SEL_SUB = 3'b101;
	localparam logic [2:0] SEL_CMP = 3'b111;
	localparam logic [2:0] RM_DIRECT = 3'b110;
	localparam logic [1:0] MOD_DISP8 = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;
	localparam logic [1:0] MOD_MEM = 2'd0;
	localparam logic [1:0] MOD_REG = 2'd3;

	// Input word: one code byte.
	typedef struct packed {
		logic [7:0] code_byte;
		logic       end_of_buffer;
	} code_word_t;

	// Output word: one decoded instruction or error.
	typedef struct packed {
		operation_t         operation;
		form_t              form;
		logic               word_width;
		logic               reg_is_dest;
		logic [1:0]         mode_bits;
		logic [2:0]         reg_bits;
		logic [2:0]         rm_bits;
		logic signed [15:0] displacement;
		logic [15:0]        immediate;
		logic [2:0]         length;
		status_t            status;
	} result_word_t;

	// State carried from byte to byte.
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] imm;
		logic [2:0]  taken;
	} decode_state_t;

	function automatic kind_t classify(input logic [7:0] op);
		kind_t k;
		if (op inside {8'b100010??, 8'b000000??, 8'b001010??, 8'b001110??}) begin
			k = K_RMREG;
		end else if (op inside {8'b100000??}) begin
			k = K_GROUP;
		end else if (op inside {8'b1011????}) begin
			k = K_MOVIR;
		end else if (op inside {8'b0000010?, 8'b0010110?, 8'b0011110?}) begin
			k = K_ACC;
		end else if (op inside {8'b1100011?}) begin
			k = K_MOVIRM;
		end else begin
			k = K_UNKNOWN;
		end
		return k;
	endfunction

	function automatic operation_t op_of_sel(input logic [2:0] sel);
		operation_t o;
		if (sel == SEL_ADD) begin
			o = OP_ADD;
		end else if (sel == SEL_SUB) begin
			o = OP_SUB;
		end else begin
			o = OP_CMP;
		end
		return o;
	endfunction

	// Number of displacement bytes that follow a ModRM byte.
	function automatic logic [1:0] disp_count(input logic [7:0] modrm);
		logic [1:0] n;
		case (modrm[7:6])
			MOD_MEM:    n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
			MOD_DISP8:  n = 2'd1;
			MOD_DISP16: n = 2'd2;
			default:    n = 2'd0;
		endcase
		return n;
	endfunction

	// Number of immediate bytes an opcode carries.
	function automatic logic [1:0] imm_count(input logic [7:0] op);
		logic [1:0] n;
		case (classify(op))
			K_GROUP: n = (op[1:0] == 2'b01) ? 2'd2 : 2'd1;
			K_MOVIR: n = op[3] ? 2'd2 : 2'd1;
			K_ACC:   n = op[0] ? 2'd2 : 2'd1;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

// File: rtl/x86p_chan_if.sv
// ----------------------------------------------------------------------------
// x86p_chan_if: valid/ready channel
// One word moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface x86p_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/x86p_step.sv
// ----------------------------------------------------------------------------
// x86p_step: per-byte decode step
// Combines the stored decoder state with one code byte, giving the next
// state and, when an instruction ends or fails, the result word.
// ----------------------------------------------------------------------------
module x86p_step (
	input  x86p_pkg::decode_state_t st,
	input  x86p_pkg::code_word_t    word,
	output x86p_pkg::decode_state_t next_st,
	output logic                    emit,
	output x86p_pkg::result_word_t  res
);
	import x86p_pkg::*;

	logic    done;
	logic    err;
	status_t err_code;
	kind_t   k_new;
	kind_t   k_cur;
	logic [7:0] b;
	logic [2:0] sel;

	assign b     = word.code_byte;
	assign sel   = b[5:3];
	assign k_new = classify(b);
	assign k_cur = classify(st.opcode);

	// Phase advance and field collection.
	always_comb begin
		next_st  = st;
		done     = 1'b0;
		err      = 1'b0;
		err_code = ST_OK;
		case (st.phase)
			PH_MODRM: begin
				next_st.taken = st.taken + 3'd1;
				next_st.modrm = b;
				if (k_cur == K_GROUP && sel != SEL_ADD && sel != SEL_SUB && sel != SEL_CMP) begin
					err      = 1'b1;
					err_code = ST_BAD_SUBOP;
				end else if (disp_count(b) != 2'd0) begin
					next_st.phase = PH_DISP_LO;
				end else if (imm_count(st.opcode) != 2'd0) begin
					next_st.phase = PH_IMM_LO;
				end else begin
					done = 1'b1;
				end
			end
			PH_DISP_LO: begin
				next_st.taken = st.taken + 3'd1;
				next_st.disp  = {8'h00, b};
				if (disp_count(st.modrm) == 2'd2) begin
					next_st.phase = PH_DISP_HI;
				end else if (imm_count(st.opcode) != 2'd0) begin
					next_st.phase = PH_IMM_LO;
				end else begin
					done = 1'b1;
				end
			end
			PH_DISP_HI: begin
				next_st.taken = st.taken + 3'd1;
				next_st.disp  = {b, st.disp[7:0]};
				if (imm_count(st.opcode) != 2'd0) begin
					next_st.phase = PH_IMM_LO;
				end else begin
					done = 1'b1;
				end
			end
			PH_IMM_LO: begin
				next_st.taken = st.taken + 3'd1;
				next_st.imm   = {8'h00, b};
				if (imm_count(st.opcode) == 2'd2) begin
					next_st.phase = PH_IMM_HI;
				end else begin
					done = 1'b1;
				end
			end
			PH_IMM_HI: begin
				next_st.taken = st.taken + 3'd1;
				next_st.imm   = {b, st.imm[7:0]};
				done          = 1'b1;
			end
			default: begin
				// New instruction starts with this byte.
				next_st.opcode = b;
				next_st.modrm  = 8'h00;
				next_st.disp   = 16'h0000;
				next_st.imm    = 16'h0000;
				next_st.taken  = 3'd1;
				if (k_new == K_UNKNOWN) begin
					err      = 1'b1;
					err_code = ST_UNKNOWN;
				end else if (k_new == K_MOVIRM) begin
					err      = 1'b1;
					err_code = ST_NOT_IMPL;
				end else if (k_new == K_MOVIR || k_new == K_ACC) begin
					next_st.phase = PH_IMM_LO;
				end else begin
					next_st.phase = PH_MODRM;
				end
			end
		endcase

		// End of buffer cuts off an unfinished instruction.
		if (!done && !err && word.end_of_buffer) begin
			err      = 1'b1;
			err_code = ST_TRUNCATED;
		end
		emit = done || err;
		if (emit) begin
			next_st.phase = PH_OPCODE;
		end
	end

	// Result word built from the updated fields.
	always_comb begin
		kind_t      k;
		logic [7:0] op;
		logic [7:0] m;
		k  = classify(next_st.opcode);
		op = next_st.opcode;
		m  = next_st.modrm;
		res = '0;
		res.length = next_st.taken;
		if (err) begin
			res.status = err_code;
		end else begin
			res.status    = ST_OK;
			res.immediate = next_st.imm;
			if (k == K_RMREG || k == K_GROUP) begin
				res.mode_bits = m[7:6];
				res.reg_bits  = m[5:3];
				res.rm_bits   = m[2:0];
				if (m[7:6] == MOD_DISP8) begin
					res.displacement = {{8{next_st.disp[7]}}, next_st.disp[7:0]};
				end else begin
					res.displacement = next_st.disp;
				end
			end else begin
				res.mode_bits = MOD_REG;
				res.reg_bits  = (k == K_MOVIR) ? op[2:0] : 3'd0;
			end
			case (k)
				K_RMREG: begin
					res.operation   = (op[7:2] == 6'b100010) ? OP_MOV : op_of_sel(op[5:3]);
					res.form        = FM_RM_REG;
					res.word_width  = op[0];
					res.reg_is_dest = op[1];
					res.immediate   = 16'h0000;
				end
				K_GROUP: begin
					res.operation  = op_of_sel(m[5:3]);
					res.form       = FM_IMM_RM;
					res.word_width = op[0];
					// Sign-extended byte immediate (s=1, w=1).
					if (op[1:0] == 2'b11) begin
						res.immediate = {{8{next_st.imm[7]}}, next_st.imm[7:0]};
					end
				end
				K_MOVIR: begin
					res.operation   = OP_MOV;
					res.form        = FM_IMM_REG;
					res.word_width  = op[3];
					res.reg_is_dest = 1'b1;
				end
				default: begin
					res.operation   = op_of_sel(op[5:3]);
					res.form        = FM_IMM_ACC;
					res.word_width  = op[0];
					res.reg_is_dest = 1'b1;
				end
			endcase
		end
	end

endmodule

// File: rtl/x86_16_instruction_predecoder.sv
// ----------------------------------------------------------------------------
// x86_16_instruction_predecoder: 8086 predecoder for mov, add, sub and cmp
// Collects opcode, ModRM, displacement and immediate bytes and reports one
// decoded word per instruction, or an error word.
// ----------------------------------------------------------------------------
// Usage:
// Code bytes enter on the code channel, one word per byte, with
// end_of_buffer marking the last byte of a buffer. Decoded instructions
// leave on the result channel: one word when an instruction completes, and
// one word with a nonzero status for an unknown opcode, the mov
// immediate-to-r/m form, a bad group sub-operation or a cut-off
// instruction. Decoding restarts at the byte after any result.
// A byte is registered in the input register on acceptance; the decode step then
// takes it, and a result that it completes is written into the result register
// and offered from there. One byte is taken every cycle while the result channel does not stall; the rate is set
// by the single decode step between the input register and the result register.
// When the receiver stalls, the held result blocks the decode step and the
// input register fills, after which code.ready drops; nothing is lost.
// Reset clears both valid flags and returns the decoder to the opcode phase.
module x86_16_instruction_predecoder (
	input  logic         clk,
	input  logic         arst_n,
	x86p_chan_if.sink    code,
	x86p_chan_if.source  result
);
	import x86p_pkg::*;

	code_word_t    code_s1;
	logic          valid_s1;
	decode_state_t st_q;
	decode_state_t next_st;
	logic          step_emit;
	result_word_t  step_res;
	result_word_t  result_q;
	logic          out_valid_q;
	logic          advance;

	// The step runs when the result register can take its output.
	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign code.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code.ready) begin
			valid_s1 <= code.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code.valid && code.ready) begin
			code_s1 <= code.data;
		end
	end

	x86p_step u_step (
		.st      (st_q),
		.word    (code_s1),
		.next_st (next_st),
		.emit    (step_emit),
		.res     (step_res)
	);

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_OPCODE, opcode: 8'h00, modrm: 8'h00,
				disp: 16'h0000, imm: 16'h0000, taken: 3'd0};
		end else if (advance) begin
			st_q <= next_st;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step_emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_emit) begin
			result_q <= step_res;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = result_q;

	// Any reported word sends the decoder back to the opcode phase.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_emit |=> st_q.phase == PH_OPCODE)
		else $error("decoder not back at opcode phase after a result");

	// A byte held in the input register is not dropped or altered.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(code_s1))
		else $error("stalled code byte lost");

	// Error words carry only length and status.
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.status != ST_OK |->
		result_q.displacement == 16'sd0 && result_q.immediate == 16'h0000 &&
		result_q.operation == OP_MOV && result_q.form == FM_RM_REG)
		else $error("error word carries decoded fields");

	// Every reported word consumed at least one byte.
	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> result_q.length != 3'd0)
		else $error("result with zero length");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 8086 instruction predecoder
// Feeds code bytes through the code channel and checks every decoded word
// against an in-bench decoder model. It runs a short directed script of edge
// cases first, and then random instructions mixed with noise bytes and
// buffer ends. Both channels idle at random, and one long receiver stall
// backs the pipeline up into the code channel.
// ----------------------------------------------------------------------------
module tb_top;
	import x86p_pkg::*;

	// One row of the directed script; typed rows carry their own error result.
	typedef struct {
		logic [7:0] code;
		logic       last;
		bit         typed;
		status_t    st;
		logic [2:0] len;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	x86p_chan_if #(.T(code_word_t))   code_ch ();
	x86p_chan_if #(.T(result_word_t)) result_ch ();

	x86_16_instruction_predecoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_ch),
		.result (result_ch)
	);

	decode_state_t track;
	result_word_t  decoded_q [$];
	int            bytes_sent;
	int            fail_count;
	bit            steady;
	bit            hold_pending;
	int            hold_left;

	script_row_t script [26] = '{
		'{8'h0F, 1'b0, 1'b1, ST_UNKNOWN,   3'd1},
		'{8'hFF, 1'b1, 1'b1, ST_UNKNOWN,   3'd1},
		'{8'hC7, 1'b0, 1'b1, ST_NOT_IMPL,  3'd1},
		'{8'h80, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'hC8, 1'b0, 1'b1, ST_BAD_SUBOP, 3'd2},
		'{8'h8B, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h06, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h34, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h12, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h01, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h47, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h80, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h83, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h87, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h00, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h80, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h3D, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'hFF, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h2C, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h7F, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'hB0, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h00, 1'b1, 1'b0, ST_OK,        3'd0},
		'{8'h81, 1'b0, 1'b0, ST_OK,        3'd0},
		'{8'h06, 1'b1, 1'b1, ST_TRUNCATED, 3'd2}
	};

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Opcode class from the opcode bit patterns.
	function automatic kind_t opcode_kind(input logic [7:0] op);
		if (op[7:2] == 6'b100010 || op[7:2] == 6'b000000 ||
			op[7:2] == 6'b001010 || op[7:2] == 6'b001110) begin
			return K_RMREG;
		end
		if (op[7:2] == 6'b100000) return K_GROUP;
		if (op[7:4] == 4'b1011) return K_MOVIR;
		if (op[7:1] == 7'b0000010 || op[7:1] == 7'b0010110 ||
			op[7:1] == 7'b0011110) begin
			return K_ACC;
		end
		if (op[7:1] == 7'b1100011) return K_MOVIRM;
		return K_UNKNOWN;
	endfunction

	// Arithmetic selector to operation: add, sub, and cmp for anything else.
	function automatic operation_t sel_operation(input logic [2:0] sel);
		if (sel == SEL_ADD) return OP_ADD;
		if (sel == SEL_SUB) return OP_SUB;
		return OP_CMP;
	endfunction

	// Displacement bytes that follow a given ModRM byte.
	function automatic int disp_bytes(input logic [7:0] m);
		if (m[7:6] == MOD_MEM) return (m[2:0] == RM_DIRECT) ? 2 : 0;
		if (m[7:6] == MOD_DISP8) return 1;
		if (m[7:6] == MOD_DISP16) return 2;
		return 0;
	endfunction

	// Immediate bytes carried by a given opcode.
	function automatic int imm_bytes(input logic [7:0] op);
		case (opcode_kind(op))
			K_GROUP: return (op[1:0] == 2'b01) ? 2 : 1;
			K_MOVIR: return op[3] ? 2 : 1;
			K_ACC:   return op[0] ? 2 : 1;
			default: return 0;
		endcase
	endfunction

	// Advances the decoder model by one code byte; returns 1 with the word
	// that the byte completes, if any.
	function automatic bit decode_byte(input code_word_t w, output result_word_t r);
		kind_t      k;
		logic [2:0] sel;
		logic [7:0] b;
		bit         done;
		bit         failed;
		status_t    why;
		r = '0;
		b = w.code_byte;
		done = 1'b0;
		failed = 1'b0;
		why = ST_OK;
		if (track.phase == PH_OPCODE) begin
			track.opcode = b;
			track.modrm = '0;
			track.disp = '0;
			track.imm = '0;
			track.taken = 3'd1;
			k = opcode_kind(b);
			if (k == K_UNKNOWN) begin
				failed = 1'b1;
				why = ST_UNKNOWN;
			end else if (k == K_MOVIRM) begin
				failed = 1'b1;
				why = ST_NOT_IMPL;
			end else begin
				track.phase = (k == K_MOVIR || k == K_ACC) ? PH_IMM_LO : PH_MODRM;
			end
		end else begin
			track.taken = track.taken + 3'd1;
			case (track.phase)
				PH_MODRM: begin
					track.modrm = b;
					sel = b[5:3];
					if (opcode_kind(track.opcode) == K_GROUP && sel != SEL_ADD &&
						sel != SEL_SUB && sel != SEL_CMP) begin
						failed = 1'b1;
						why = ST_BAD_SUBOP;
					end else if (disp_bytes(b) > 0) begin
						track.phase = PH_DISP_LO;
					end else if (imm_bytes(track.opcode) > 0) begin
						track.phase = PH_IMM_LO;
					end else begin
						done = 1'b1;
					end
				end
				PH_DISP_LO: begin
					track.disp = {8'h00, b};
					if (disp_bytes(track.modrm) == 2) begin
						track.phase = PH_DISP_HI;
					end else if (imm_bytes(track.opcode) > 0) begin
						track.phase = PH_IMM_LO;
					end else begin
						done = 1'b1;
					end
				end
				PH_DISP_HI: begin
					track.disp[15:8] = b;
					if (imm_bytes(track.opcode) > 0) begin
						track.phase = PH_IMM_LO;
					end else begin
						done = 1'b1;
					end
				end
				PH_IMM_LO: begin
					track.imm = {8'h00, b};
					if (imm_bytes(track.opcode) == 2) begin
						track.phase = PH_IMM_HI;
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					track.imm[15:8] = b;
					done = 1'b1;
				end
			endcase
		end

		// Errors and cut-off instructions report only length and status.
		if (failed || (!done && w.end_of_buffer)) begin
			r.length = track.taken;
			r.status = failed ? why : ST_TRUNCATED;
			track.phase = PH_OPCODE;
			return 1'b1;
		end
		if (!done) return 1'b0;

		// A complete instruction.
		k = opcode_kind(track.opcode);
		if (k == K_RMREG || k == K_GROUP) begin
			r.mode_bits = track.modrm[7:6];
			r.reg_bits = track.modrm[5:3];
			r.rm_bits = track.modrm[2:0];
			r.displacement = (track.modrm[7:6] == MOD_DISP8 && track.disp[7]) ?
				{8'hFF, track.disp[7:0]} : track.disp;
		end else begin
			r.mode_bits = MOD_REG;
			r.reg_bits = (k == K_MOVIR) ? track.opcode[2:0] : 3'd0;
		end
		case (k)
			K_RMREG: begin
				r.operation = (track.opcode[7:2] == 6'b100010) ? OP_MOV :
					sel_operation(track.opcode[5:3]);
				r.form = FM_RM_REG;
				r.word_width = track.opcode[0];
				r.reg_is_dest = track.opcode[1];
			end
			K_GROUP: begin
				r.operation = sel_operation(track.modrm[5:3]);
				r.form = FM_IMM_RM;
				r.word_width = track.opcode[0];
				r.immediate = (track.opcode[1:0] == 2'b11 && track.imm[7]) ?
					{8'hFF, track.imm[7:0]} : track.imm;
			end
			K_MOVIR: begin
				r.operation = OP_MOV;
				r.form = FM_IMM_REG;
				r.word_width = track.opcode[3];
				r.reg_is_dest = 1'b1;
				r.immediate = track.imm;
			end
			default: begin
				r.operation = sel_operation(track.opcode[5:3]);
				r.form = FM_IMM_ACC;
				r.word_width = track.opcode[0];
				r.reg_is_dest = 1'b1;
				r.immediate = track.imm;
			end
		endcase
		r.length = track.taken;
		r.status = ST_OK;
		track.phase = PH_OPCODE;
		return 1'b1;
	endfunction

	function automatic string show(input result_word_t r);
		return $sformatf({"op=%0d form=%0d w=%0d d=%0d mod=%0d reg=%0d rm=%0d ",
			"disp=%h imm=%h len=%0d st=%0d"},
			r.operation, r.form, r.word_width, r.reg_is_dest, r.mode_bits, r.reg_bits,
			r.rm_bits, r.displacement, r.immediate, r.length, r.status);
	endfunction

	// Offers one code word after a random gap and waits until it is taken.
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
		input result_word_t typed_res);
		result_word_t r;
		code_word_t   w;
		w.code_byte = b;
		w.end_of_buffer = last;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 30) begin
			code_ch.valid <= 1'b0;
			@(negedge clk);
		end
		code_ch.valid <= 1'b1;
		code_ch.data <= w;
		do @(posedge clk); while (!code_ch.ready);
		bytes_sent++;
		if (decode_byte(w, r)) decoded_q.push_back(typed ? typed_res : r);
	endtask

	// One random instruction, or a noise byte; some get a buffer end inside.
	task automatic send_random_instruction();
		logic [7:0] seq [$];
		logic [7:0] opc;
		logic [7:0] mrm;
		int         pick;
		int         n;
		int         cut;
		pick = $urandom_range(99);
		if (pick < 10) begin
			send_byte(8'($urandom_range(255)), $urandom_range(19) == 0, 1'b0, '0);
			return;
		end
		mrm = 8'($urandom_range(255));
		if (pick < 40) begin
			case ($urandom_range(3))
				0: opc = {6'b100010, 2'($urandom_range(3))};
				1: opc = {6'b000000, 2'($urandom_range(3))};
				2: opc = {6'b001010, 2'($urandom_range(3))};
				default: opc = {6'b001110, 2'($urandom_range(3))};
			endcase
		end else if (pick < 65) begin
			opc = {6'b100000, 2'($urandom_range(3))};
			if ($urandom_range(9) != 0) begin
				case ($urandom_range(2))
					0: mrm[5:3] = SEL_ADD;
					1: mrm[5:3] = SEL_SUB;
					default: mrm[5:3] = SEL_CMP;
				endcase
			end
		end else if (pick < 80) begin
			opc = {4'b1011, 4'($urandom_range(15))};
		end else begin
			case ($urandom_range(2))
				0: opc = {7'b0000010, 1'($urandom_range(1))};
				1: opc = {7'b0010110, 1'($urandom_range(1))};
				default: opc = {7'b0011110, 1'($urandom_range(1))};
			endcase
		end
		seq.push_back(opc);
		if (opcode_kind(opc) == K_RMREG || opcode_kind(opc) == K_GROUP) begin
			seq.push_back(mrm);
			// A bad group sub-operation ends the instruction at the ModRM byte.
			if (!(opcode_kind(opc) == K_GROUP && mrm[5:3] != SEL_ADD &&
				mrm[5:3] != SEL_SUB && mrm[5:3] != SEL_CMP)) begin
				n = disp_bytes(mrm) + imm_bytes(opc);
				repeat (n) seq.push_back(8'($urandom_range(255)));
			end
		end else begin
			repeat (imm_bytes(opc)) seq.push_back(8'($urandom_range(255)));
		end
		cut = ($urandom_range(99) < 8) ? int'($urandom_range(seq.size() - 1)) : -1;
		foreach (seq[i]) begin
			send_byte(seq[i], i == cut, 1'b0, '0);
			if (i == cut) break;
		end
	endtask

	// Result receiver: random backpressure, plus one long hold-off on request.
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || $urandom_range(99) >= 30;
			end
		end
	end

	// Compare every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		result_word_t want;
		result_word_t got;
		if (result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (decoded_q.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("unexpected result word: %s", show(got));
			end else begin
				want = decoded_q.pop_front();
				if (got.operation !== want.operation || got.form !== want.form ||
					got.word_width !== want.word_width ||
					got.reg_is_dest !== want.reg_is_dest ||
					got.mode_bits !== want.mode_bits || got.reg_bits !== want.reg_bits ||
					got.rm_bits !== want.rm_bits ||
					got.displacement !== want.displacement ||
					got.immediate !== want.immediate || got.length !== want.length ||
					got.status !== want.status) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("result word differs at %0t", $realtime);
						$display("  expected %s", show(want));
						$display("  actual   %s", show(got));
					end
				end
			end
		end
	end

	// Stimulus: reset, directed script, random instructions, drain.
	initial begin
		result_word_t typed_res;
		arst_n = 1'b0;
		code_ch.valid = 1'b0;
		code_ch.data = '0;
		track = '0;
		track.phase = PH_OPCODE;
		bytes_sent = 0;
		fail_count = 0;
		steady = 1'b0;
		hold_pending = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			typed_res = '0;
			typed_res.length = script[i].len;
			typed_res.status = script[i].st;
			send_byte(script[i].code, script[i].last, script[i].typed, typed_res);
		end

		// The long hold-off comes at the start of the random part.
		hold_pending = 1'b1;
		while (bytes_sent < 1050) begin
			steady = (bytes_sent >= 600 && bytes_sent < 760);
			send_random_instruction();
		end
		steady = 1'b0;
		@(negedge clk);
		code_ch.valid <= 1'b0;

		while (decoded_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("x86_16_instruction_predecoder: match");
		end else begin
			$display("x86_16_instruction_predecoder: mismatch");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("x86_16_instruction_predecoder: mismatch");
		$finish;
	end

endmodule
